// File: rtl/sorted_byte_list_core_macros.svh
// assertion macros used by sorted_byte_list_core
`ifndef SORTED_BYTE_LIST_CORE_MACROS_SVH
`define SORTED_BYTE_LIST_CORE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SBL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define SBL_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/sbl_pkg.sv
`timescale 1ns / 1ps

package sbl_pkg;

  localparam int DATA_W      = 8;
  localparam int COUNT_OUT_W = 5;
  localparam int CAPACITY    = 16;

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } sbl_op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } sbl_status_t;

  // input beat
  typedef struct packed {
    sbl_op_t                   func;
    logic signed [DATA_W-1:0]  value;
  } sbl_in_t;

  // result beat
  typedef struct packed {
    sbl_status_t                status;
    logic signed [DATA_W-1:0]   popped;
    logic [COUNT_OUT_W-1:0]     entry_count;
  } sbl_out_t;

  // shift commands broadcast to the cell row
  typedef struct packed {
    logic ins;
    logic rem;
    logic pop;
  } sbl_ctrl_t;

endpackage

// File: rtl/sbl_cell.sv
`timescale 1ns / 1ps

module sbl_cell (
  input  logic                               clk,
  input  sbl_pkg::sbl_ctrl_t                 ctrl,
  input  logic signed [sbl_pkg::DATA_W-1:0]  value,
  input  logic                               valid,
  input  logic                               left_lt,
  input  logic signed [sbl_pkg::DATA_W-1:0]  left_data,
  input  logic signed [sbl_pkg::DATA_W-1:0]  right_data,
  output logic signed [sbl_pkg::DATA_W-1:0]  data,
  output logic                               lt,
  output logic                               hit
);

  // held entry smaller than the operand; true for a prefix of the row
  assign lt  = valid && (data < value);

  // first entry not smaller than the operand, and equal to it
  assign hit = valid && !lt && left_lt && (data == value);

  // insert opens a gap at the boundary, remove and pop close one
  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      data <= left_lt ? value : left_data;
    end else if (ctrl.rem && !lt) begin
      data <= right_data;
    end else if (ctrl.pop) begin
      data <= right_data;
    end
  end

endmodule

// File: rtl/sorted_byte_list_core.sv
// result: done and the result beat are registered and appear in the cycle after the command is accepted
// throughput: one command per cycle, busy stays low outside reset
// the compare-and-shift row of cells settles insert, remove and pop in all cells in parallel
// results are never held back: done pulses for exactly one cycle per command
// reset: entry count and done clear, busy is high while rst is high
// cell contents are not cleared; only entries below the count are ever read
`timescale 1ns / 1ps

`include "sorted_byte_list_core_macros.svh"

module sorted_byte_list_core #(
  parameter int CAPACITY = sbl_pkg::CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sbl_pkg::sbl_in_t  cmd,
  output logic              done,
  output sbl_pkg::sbl_out_t result
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               accept;
  sbl_pkg::sbl_ctrl_t ctrl;
  sbl_pkg::sbl_out_t  result_next;

  logic signed [sbl_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]               cell_lt;
  logic [CAPACITY-1:0]               cell_hit;
  logic                              found;

  assign busy   = rst;
  assign accept = start && !busy;
  assign found  = |cell_hit;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                              left_lt;
    logic signed [sbl_pkg::DATA_W-1:0] left_data;
    logic signed [sbl_pkg::DATA_W-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_lt   = 1'b1;
      assign left_data = cmd.value;
    end else begin : g_body
      assign left_lt   = cell_lt[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    sbl_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .value      (cmd.value),
      .valid      (CW'(i) < count),
      .left_lt    (left_lt),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .lt         (cell_lt[i]),
      .hit        (cell_hit[i])
    );
  end

  // operation decode
  always_comb begin
    ctrl                    = '0;
    count_next              = count;
    result_next.status      = sbl_pkg::ST_OK;
    result_next.popped      = '0;
    unique case (cmd.func)
      sbl_pkg::OP_INSERT: begin
        if (count == CW'(CAPACITY)) begin
          result_next.status = sbl_pkg::ST_FULL;
        end else begin
          ctrl.ins   = accept;
          count_next = count + CW'(1);
        end
      end
      sbl_pkg::OP_REMOVE: begin
        if (found) begin
          ctrl.rem   = accept;
          count_next = count - CW'(1);
        end else begin
          result_next.status = sbl_pkg::ST_NO_MATCH;
        end
      end
      sbl_pkg::OP_POP: begin
        if (count == '0) begin
          result_next.status = sbl_pkg::ST_EMPTY;
        end else begin
          ctrl.pop           = accept;
          count_next         = count - CW'(1);
          result_next.popped = cell_data[0];
        end
      end
      default: begin
      end
    endcase
    result_next.entry_count = sbl_pkg::COUNT_OUT_W'(count_next);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  `SBL_NEVER(a_count_range, count > CW'(CAPACITY), "entry count above capacity")
  `SBL_ASSERT(a_done_follows, done |-> $past(accept), "result beat without a command")
  `SBL_ASSERT(a_full_holds,
    (done && result.status == sbl_pkg::ST_FULL) |-> (count == CW'(CAPACITY)),
    "refused insert but list not full")
  `SBL_ASSERT(a_count_step,
    (done && result.status != sbl_pkg::ST_OK) |-> (count == $past(count)),
    "failed operation changed the count")

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM   = 1000;
  localparam int N_TOTAL    = N_DIRECTED + N_RANDOM;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 4;

  // one directed command beat, with its result typed in where it is obvious
  typedef struct {
    sbl_pkg::sbl_in_t  beat;
    bit                fixed;
    sbl_pkg::sbl_out_t want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  sbl_pkg::sbl_in_t  cmd = '0;
  logic              done;
  sbl_pkg::sbl_out_t result;

  sorted_byte_list_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  stim_row_t                         stim_table [N_DIRECTED];
  logic signed [sbl_pkg::DATA_W-1:0] held_list [$];
  sbl_pkg::sbl_out_t                 pending_results [$];
  int                                n_issued = 0;
  int                                n_accepted = 0;
  bit                                feed_done = 1'b0;
  bit                                drain_mode = 1'b0;
  bit                                bus_fixed = 1'b0;
  sbl_pkg::sbl_out_t                 bus_want;
  int                                errors = 0;
  int                                stall_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // directed beats: empty-list cases, fill with extremes and duplicates, full, then removes, a pop and a no-op
  initial begin
    stim_table = '{
      '{'{sbl_pkg::OP_POP,    8'sd0},    1'b1, '{sbl_pkg::ST_EMPTY,    8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_REMOVE, 8'sd0},    1'b1, '{sbl_pkg::ST_NO_MATCH, 8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_NONE,   -8'sd1},   1'b1, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, 8'sh80},   1'b1, '{sbl_pkg::ST_OK,       8'sd0, 5'd1}},
      '{'{sbl_pkg::OP_INSERT, 8'sd127},  1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, 8'sd0},    1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, 8'sd0},    1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, -8'sd1},   1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, 8'sd1},    1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, 8'sd85},   1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, -8'sd86},  1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, 8'sd64},   1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, -8'sd64},  1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, 8'sd5},    1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, 8'sd5},    1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, 8'sd5},    1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, -8'sd5},   1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, 8'sd100},  1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, -8'sd100}, 1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_INSERT, 8'sd3},    1'b1, '{sbl_pkg::ST_FULL,     8'sd0, 5'd16}},
      '{'{sbl_pkg::OP_REMOVE, 8'sd127},  1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_REMOVE, 8'sh80},   1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_REMOVE, 8'sd42},   1'b1, '{sbl_pkg::ST_NO_MATCH, 8'sd0, 5'd14}},
      '{'{sbl_pkg::OP_POP,    8'sd77},   1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}},
      '{'{sbl_pkg::OP_NONE,   8'sd42},   1'b0, '{sbl_pkg::ST_OK,       8'sd0, 5'd0}}
    };
  end

  // sorted list predictor: applies one command beat, returns the result beat
  function automatic sbl_pkg::sbl_out_t apply_cmd(sbl_pkg::sbl_in_t b);
    sbl_pkg::sbl_out_t                 r;
    logic signed [sbl_pkg::DATA_W-1:0] v;
    int                                pos;
    r = '0;
    v = $signed(b.value);
    r.status = sbl_pkg::ST_OK;
    case (b.func)
      sbl_pkg::OP_INSERT: begin
        if (held_list.size() >= sbl_pkg::CAPACITY) begin
          r.status = sbl_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_list.size() && held_list[pos] < v) pos++;
          held_list.insert(pos, v);
        end
      end
      sbl_pkg::OP_REMOVE: begin
        pos = 0;
        while (pos < held_list.size() && held_list[pos] != v) pos++;
        if (pos >= held_list.size()) r.status = sbl_pkg::ST_NO_MATCH;
        else held_list.delete(pos);
      end
      sbl_pkg::OP_POP: begin
        if (held_list.size() == 0) r.status = sbl_pkg::ST_EMPTY;
        else r.popped = held_list.pop_front();
      end
      default: ;
    endcase
    r.entry_count = sbl_pkg::COUNT_OUT_W'(held_list.size());
    return r;
  endfunction

  // random beat: alternates between filling and draining so full and empty are reached
  function automatic sbl_pkg::sbl_in_t random_cmd();
    sbl_pkg::sbl_in_t b;
    int               pick;
    if (held_list.size() == sbl_pkg::CAPACITY) drain_mode = 1'b1;
    else if (held_list.size() == 0) drain_mode = 1'b0;
    else if ($urandom_range(49) == 0) drain_mode = !drain_mode;
    pick = $urandom_range(99);
    b.value = sbl_pkg::DATA_W'($urandom);
    if (pick < (drain_mode ? 20 : 65)) begin
      b.func = sbl_pkg::OP_INSERT;
      // narrow values give plenty of duplicates
      if ($urandom_range(1) == 0)
        b.value = $signed(sbl_pkg::DATA_W'($urandom_range(8))) - 8'sd4;
    end else if (pick < (drain_mode ? 55 : 80)) begin
      b.func = sbl_pkg::OP_REMOVE;
      if (held_list.size() > 0 && $urandom_range(4) < 3)
        b.value = held_list[$urandom_range(held_list.size() - 1)];
    end else if (pick < 97) begin
      b.func = sbl_pkg::OP_POP;
    end else begin
      b.func = sbl_pkg::OP_NONE;
    end
    return b;
  endfunction

  // command driver: predicts on each accepted beat, then presents the next one
  always @(posedge clk) begin : feed
    sbl_pkg::sbl_out_t want;
    int                idle_pct;
    if (!rst) begin
      if (start && !busy) begin
        want = apply_cmd(cmd);
        if (bus_fixed) want = bus_want;
        pending_results.push_back(want);
        n_accepted++;
        if (n_accepted == N_TOTAL) feed_done = 1'b1;
      end
      if (n_issued < N_TOTAL / 3) idle_pct = 33;
      else if (n_issued < 2 * N_TOTAL / 3) idle_pct = 59;
      else idle_pct = 0;
      if (start && busy) begin
        // hold the beat until it is taken
      end else if (n_issued == N_TOTAL || $urandom_range(99) < idle_pct) begin
        start <= 1'b0;
      end else if (n_issued < N_DIRECTED) begin
        start <= 1'b1;
        cmd <= stim_table[n_issued].beat;
        bus_fixed = stim_table[n_issued].fixed;
        bus_want = stim_table[n_issued].want;
        n_issued++;
      end else begin
        start <= 1'b1;
        cmd <= random_cmd();
        bus_fixed = 1'b0;
        n_issued++;
      end
    end
  end

  // result checker: oldest expectation against each done beat
  always @(posedge clk) begin : check
    sbl_pkg::sbl_out_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %p", $time, result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, result.status);
          errors++;
        end
        if (result.popped !== want.popped) begin
          $display("%0t: popped expected %0d got %0d", $time,
                   $signed(want.popped), $signed(result.popped));
          errors++;
        end
        if (result.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d got %0d", $time,
                   want.entry_count, result.entry_count);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // reset, then wait for all beats and results
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (!(feed_done && pending_results.size() == 0)) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
